// ===== rtl/hlb_pkg.sv =====
// shared types and constants for the heartbeat lru worker balancer
package hlb_pkg;

  localparam int unsigned MAX_WORKERS_DEF = 16;
  localparam int unsigned HB_CAP          = 16;

  localparam logic [15:0] INTERVAL_RST = 16'd1000;
  localparam logic [3:0]  LIVENESS_RST = 4'd3;

  localparam logic CFG_INTERVAL = 1'b0;
  localparam logic CFG_LIVENESS = 1'b1;

  localparam logic [1:0] REQ_WORKER = 2'd0;
  localparam logic [1:0] REQ_CLIENT = 2'd1;
  localparam logic [1:0] REQ_TICK   = 2'd2;
  localparam logic [1:0] REQ_RSVD   = 2'd3;

  localparam logic [7:0] CODE_READY     = 8'd1;
  localparam logic [7:0] CODE_HEARTBEAT = 8'd2;

  localparam logic [2:0] ACT_NONE      = 3'd0;
  localparam logic [2:0] ACT_FORWARD   = 3'd1;
  localparam logic [2:0] ACT_DISPATCH  = 3'd2;
  localparam logic [2:0] ACT_HEARTBEAT = 3'd3;
  localparam logic [2:0] ACT_INVALID   = 3'd4;
  localparam logic [2:0] ACT_NO_WORKER = 3'd5;

  typedef enum logic [1:0] {
    OP_WORKER,
    OP_CLIENT,
    OP_TICK,
    OP_NONE
  } op_e;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_SRCH_RD,
    ST_SRCH_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_APPEND,
    ST_CLIENT_RD,
    ST_CLIENT_OUT,
    ST_PURGE_RD,
    ST_PURGE_CMP,
    ST_HB_RD,
    ST_HB_OUT,
    ST_RESULT
  } bst_e;

  typedef struct packed {
    logic [1:0]  req_type;
    logic [31:0] worker_id;
    logic [31:0] now_ms;
    logic        is_control;
    logic [7:0]  control_code;
  } in_item_t;

  typedef struct packed {
    logic [2:0]  action;
    logic [31:0] target_worker;
    logic [4:0]  ready_count;
    logic        accepting_clients;
    logic        last;
  } out_item_t;

  typedef struct packed {
    op_e         op;
    logic [2:0]  act;
    logic [31:0] wid;
    logic [31:0] now;
    logic [31:0] expiry;
  } q_item_t;

endpackage

// ===== rtl/heartbeat_lru_worker_balancer_top.sv =====
// top level of the heartbeat lru worker balancer
// usage:
//   in channel (in_valid_i/in_ready_o/in_data_i) takes worker messages, client
//   requests and heartbeat ticks; out channel (out_valid_o/out_ready_i/out_data_o)
//   gives one or more result items per input item, the final one flagged last.
//   cfg_we_i/cfg_idx_i/cfg_data_i write the heartbeat interval (index 0) and the
//   liveness (index 1); write only while the block is idle.
// operation:
//   a two-entry queue parts the front from the list engine. a client request
//   reads the list head; a worker message searches the list for its id, moves
//   any later entries up to close the gap, then appends; a tick purges expired
//   entries from the head, then sends heartbeats. the engine takes a new item
//   only once it is back in idle.
// reset: the ready list is empty, interval 1000 ms, liveness 3.
// a stalled receiver holds the result register; the engine waits and the
// front queue keeps taking items until it is full.
module heartbeat_lru_worker_balancer_top import hlb_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  output logic        out_valid_o,
  input  logic        out_ready_i,
  output out_item_t   out_data_o,
  input  logic        cfg_we_i,
  input  logic        cfg_idx_i,
  input  logic [15:0] cfg_data_i
);

  logic [15:0] interval_q;
  logic [3:0]  liveness_q;
  logic        q_valid, q_ready;
  q_item_t     q_item;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      interval_q <= INTERVAL_RST;
      liveness_q <= LIVENESS_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        CFG_INTERVAL: interval_q <= cfg_data_i;
        CFG_LIVENESS: liveness_q <= cfg_data_i[3:0];
        default: ;
      endcase
    end
  end

  hlb_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .in_data_i  (in_data_i),
    .interval_i (interval_q),
    .liveness_i (liveness_q),
    .q_valid_o  (q_valid),
    .q_ready_i  (q_ready),
    .q_item_o   (q_item)
  );

  hlb_back #(
    .MAX_WORKERS (MAX_WORKERS)
  ) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .q_valid_i   (q_valid),
    .q_ready_o   (q_ready),
    .q_item_i    (q_item),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

endmodule

// ===== rtl/hlb_front.sv =====
// front end: accepts items, classifies them and queues them for the list engine
module hlb_front import hlb_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        in_valid_i,
  output logic        in_ready_o,
  input  in_item_t    in_data_i,
  input  logic [15:0] interval_i,
  input  logic [3:0]  liveness_i,
  output logic        q_valid_o,
  input  logic        q_ready_i,
  output q_item_t     q_item_o
);

  q_item_t    ent_q [2];
  logic       wp_q, rp_q;
  logic [1:0] cnt_q;
  q_item_t    cls;
  logic [19:0] prod;
  logic       push, pop;

  assign prod = 20'(interval_i) * 20'(liveness_i);

  always_comb begin
    cls.wid    = in_data_i.worker_id;
    cls.now    = in_data_i.now_ms;
    cls.expiry = in_data_i.now_ms + 32'(prod);
    unique case (in_data_i.req_type)
      REQ_WORKER: cls.op = OP_WORKER;
      REQ_CLIENT: cls.op = OP_CLIENT;
      REQ_TICK:   cls.op = OP_TICK;
      default:    cls.op = OP_NONE;
    endcase
    if (!in_data_i.is_control) begin
      cls.act = ACT_FORWARD;
    end else if (in_data_i.control_code == CODE_READY ||
                 in_data_i.control_code == CODE_HEARTBEAT) begin
      cls.act = ACT_NONE;
    end else begin
      cls.act = ACT_INVALID;
    end
  end

  assign in_ready_o = (cnt_q != 2'd2);
  assign q_valid_o  = (cnt_q != 2'd0);
  assign q_item_o   = ent_q[rp_q];
  assign push       = in_valid_i && in_ready_o;
  assign pop        = q_valid_o && q_ready_i;

  always_ff @(posedge clk_i) begin
    if (push) begin
      ent_q[wp_q] <= cls;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wp_q  <= 1'b0;
      rp_q  <= 1'b0;
      cnt_q <= 2'd0;
    end else begin
      if (push) wp_q <= ~wp_q;
      if (pop)  rp_q <= ~rp_q;
      cnt_q <= cnt_q + 2'(push) - 2'(pop);
    end
  end

endmodule

// ===== rtl/hlb_back.sv =====
// back end: ready list in a circular memory, sequencer and result register
module hlb_back import hlb_pkg::*; #(
  parameter int unsigned MAX_WORKERS = MAX_WORKERS_DEF
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  input  logic      q_valid_i,
  output logic      q_ready_o,
  input  q_item_t   q_item_i,
  output logic      out_valid_o,
  input  logic      out_ready_i,
  output out_item_t out_data_o
);

  localparam int unsigned AW = (MAX_WORKERS > 1) ? $clog2(MAX_WORKERS) : 1;
  localparam int unsigned LW = $clog2(MAX_WORKERS + 1);
  localparam int unsigned CW = (LW > 5) ? LW : 5;
  localparam int unsigned SW = CW + 1;

  logic [31:0] ids_mem [MAX_WORKERS];
  logic [31:0] exp_mem [MAX_WORKERS];
  logic [31:0] id_rd_q, exp_rd_q;

  bst_e        state_q, state_d;
  logic [AW-1:0] hd_q, hd_d, hb_base_q, hb_base_d, hd_inc;
  logic [LW-1:0] len_q, len_d;
  logic [CW-1:0] idx_q, idx_d, len_c, rc;
  logic [4:0]  hb_cnt_q, hb_cnt_d;
  q_item_t     item_q, item_d;
  logic [2:0]  act_q, act_d;
  logic [31:0] tgt_q, tgt_d;
  logic        out_valid_q, out_valid_d;
  out_item_t   out_q, out_d;

  logic          rd_en, wr_en;
  logic [AW-1:0] rd_addr, wr_addr;
  logic [31:0]   wr_id, wr_exp, diff;
  logic          out_free;

  function automatic logic [AW-1:0] phys(input logic [AW-1:0] base,
                                         input logic [CW-1:0] off);
    logic [SW-1:0] s;
    s = SW'(base) + SW'(off);
    if (s >= SW'(MAX_WORKERS)) s = s - SW'(MAX_WORKERS);
    return s[AW-1:0];
  endfunction

  assign hd_inc   = (hd_q == AW'(MAX_WORKERS - 1)) ? '0 : hd_q + 1'b1;
  assign len_c    = CW'(len_q);
  assign rc       = CW'(len_q);
  assign out_free = !out_valid_q || out_ready_i;
  assign diff     = exp_rd_q - item_q.now;

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      ids_mem[wr_addr] <= wr_id;
      exp_mem[wr_addr] <= wr_exp;
    end
    if (rd_en) begin
      id_rd_q  <= ids_mem[rd_addr];
      exp_rd_q <= exp_mem[rd_addr];
    end
  end

  always_comb begin
    state_d     = state_q;
    hd_d        = hd_q;
    len_d       = len_q;
    idx_d       = idx_q;
    hb_base_d   = hb_base_q;
    hb_cnt_d    = hb_cnt_q;
    item_d      = item_q;
    act_d       = act_q;
    tgt_d       = tgt_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    rd_en       = 1'b0;
    rd_addr     = '0;
    wr_en       = 1'b0;
    wr_addr     = '0;
    wr_id       = item_q.wid;
    wr_exp      = item_q.expiry;
    q_ready_o   = 1'b0;

    unique case (state_q)
      ST_IDLE: begin
        q_ready_o = 1'b1;
        if (q_valid_i) begin
          item_d = q_item_i;
          idx_d  = '0;
          unique case (q_item_i.op)
            OP_WORKER: state_d = (len_q == '0) ? ST_APPEND : ST_SRCH_RD;
            OP_CLIENT: begin
              if (len_q == '0) begin
                act_d   = ACT_NO_WORKER;
                tgt_d   = '0;
                state_d = ST_RESULT;
              end else begin
                state_d = ST_CLIENT_RD;
              end
            end
            OP_TICK: begin
              hb_base_d = hd_q;
              hb_cnt_d  = (len_c >= CW'(HB_CAP)) ? 5'(HB_CAP) : rc[4:0];
              if (len_q == '0) begin
                act_d   = ACT_NONE;
                tgt_d   = '0;
                state_d = ST_RESULT;
              end else begin
                state_d = ST_PURGE_RD;
              end
            end
            default: begin
              act_d   = ACT_NONE;
              tgt_d   = '0;
              state_d = ST_RESULT;
            end
          endcase
        end
      end
      ST_SRCH_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(hd_q, idx_q);
        state_d = ST_SRCH_CMP;
      end
      ST_SRCH_CMP: begin
        if (id_rd_q == item_q.wid) begin
          if (idx_q + 1'b1 < len_c) begin
            state_d = ST_SHIFT_RD;
          end else begin
            len_d   = len_q - 1'b1;
            state_d = ST_APPEND;
          end
        end else if (idx_q + 1'b1 < len_c) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SRCH_RD;
        end else begin
          state_d = ST_APPEND;
        end
      end
      // close the gap left by the removed entry, moving each later entry one slot toward the head
      ST_SHIFT_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(hd_q, idx_q + 1'b1);
        state_d = ST_SHIFT_WR;
      end
      ST_SHIFT_WR: begin
        wr_en   = 1'b1;
        wr_addr = phys(hd_q, idx_q);
        wr_id   = id_rd_q;
        wr_exp  = exp_rd_q;
        if (idx_q + CW'(2) < len_c) begin
          idx_d   = idx_q + 1'b1;
          state_d = ST_SHIFT_RD;
        end else begin
          len_d   = len_q - 1'b1;
          state_d = ST_APPEND;
        end
      end
      // on a full list the tail slot is the old head, so evict by moving the head
      ST_APPEND: begin
        wr_en   = 1'b1;
        wr_addr = phys(hd_q, len_c);
        if (len_c == CW'(MAX_WORKERS)) begin
          hd_d = hd_inc;
        end else begin
          len_d = len_q + 1'b1;
        end
        act_d   = item_q.act;
        tgt_d   = item_q.wid;
        state_d = ST_RESULT;
      end
      ST_CLIENT_RD: begin
        rd_en   = 1'b1;
        rd_addr = hd_q;
        state_d = ST_CLIENT_OUT;
      end
      ST_CLIENT_OUT: begin
        hd_d    = hd_inc;
        len_d   = len_q - 1'b1;
        act_d   = ACT_DISPATCH;
        tgt_d   = id_rd_q;
        state_d = ST_RESULT;
      end
      ST_PURGE_RD: begin
        rd_en   = 1'b1;
        rd_addr = hd_q;
        state_d = ST_PURGE_CMP;
      end
      ST_PURGE_CMP: begin
        // alive while expiry - now is nonzero and below half the time range
        if (diff == '0 || diff[31]) begin
          hd_d  = hd_inc;
          len_d = len_q - 1'b1;
          if (len_q == LW'(1)) begin
            idx_d   = '0;
            state_d = ST_HB_RD;
          end else begin
            state_d = ST_PURGE_RD;
          end
        end else begin
          idx_d   = '0;
          state_d = ST_HB_RD;
        end
      end
      // heartbeats walk the list as it stood before the purge
      ST_HB_RD: begin
        rd_en   = 1'b1;
        rd_addr = phys(hb_base_q, idx_q);
        state_d = ST_HB_OUT;
      end
      ST_HB_OUT: begin
        if (out_free) begin
          out_valid_d                 = 1'b1;
          out_d.action                = ACT_HEARTBEAT;
          out_d.target_worker         = id_rd_q;
          out_d.ready_count           = rc[4:0];
          out_d.accepting_clients     = (len_q != '0);
          out_d.last                  = (idx_q + 1'b1 == CW'(hb_cnt_q));
          idx_d                       = idx_q + 1'b1;
          state_d = out_d.last ? ST_IDLE : ST_HB_RD;
        end
      end
      ST_RESULT: begin
        if (out_free) begin
          out_valid_d             = 1'b1;
          out_d.action            = act_q;
          out_d.target_worker     = tgt_q;
          out_d.ready_count       = rc[4:0];
          out_d.accepting_clients = (len_q != '0);
          out_d.last              = 1'b1;
          state_d                 = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i) begin
    item_q    <= item_d;
    act_q     <= act_d;
    tgt_q     <= tgt_d;
    out_q     <= out_d;
    idx_q     <= idx_d;
    hb_base_q <= hb_base_d;
    hb_cnt_q  <= hb_cnt_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      hd_q        <= '0;
      len_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      hd_q        <= hd_d;
      len_q       <= len_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule
